// File: design/apsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII greyscale image parser package
// Codes, constants and the result beat type shared by the parser files.
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int DIM_BITS_DEF = 16;
  localparam int TOKEN_BITS   = 16;
  localparam int MODE_BITS    = 2;
  localparam int BYTE_BITS    = 8;
  localparam int KIND_BITS    = 2;
  localparam int ERR_BITS     = 2;

  localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = 16'hFFFF;
  localparam logic [TOKEN_BITS-1:0] GREY_MAX  = 16'd255;
  localparam logic [BYTE_BITS-1:0]  CH_SPACE   = 8'h20;
  localparam logic [BYTE_BITS-1:0]  CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_BITS-1:0]  CH_ZERO    = 8'h30;
  localparam logic [BYTE_BITS-1:0]  CH_NINE    = 8'h39;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_DATA  = 2'd0,
    MODE_START = 2'd1,
    MODE_END   = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_NONE    = 2'd0,
    ERR_MAXVAL  = 2'd1,
    ERR_EARLY   = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    PH_MAGIC0  = 3'd0,
    PH_MAGIC1  = 3'd1,
    PH_WIDTH   = 3'd2,
    PH_HEIGHT  = 3'd3,
    PH_MAXV    = 3'd4,
    PH_PIXELS  = 3'd5,
    PH_STOPPED = 3'd6
  } phase_t;

  typedef struct packed {
    kind_t                 kind;
    logic [TOKEN_BITS-1:0] image_width;
    logic [TOKEN_BITS-1:0] image_height;
    logic [BYTE_BITS-1:0]  pixel_value;
    logic                  last_pixel;
    err_t                  error_code;
  } res_beat_t;

endpackage

// File: design/apsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII greyscale image parser channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
interface apsp_in_if;
  import apsp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_BITS-1:0] mode;
  logic [BYTE_BITS-1:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface apsp_out_if;
  import apsp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  kind;
  logic [TOKEN_BITS-1:0] image_width;
  logic [TOKEN_BITS-1:0] image_height;
  logic [BYTE_BITS-1:0]  pixel_value;
  logic                  last_pixel;
  logic [ERR_BITS-1:0]   error_code;

  modport source (output valid, output kind, output image_width, output image_height,
                  output pixel_value, output last_pixel, output error_code, input ready);
  modport sink   (input valid, input kind, input image_width, input image_height,
                  input pixel_value, input last_pixel, input error_code, output ready);
endinterface

// File: design/ascii_pgm_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII greyscale image stream parser
// Byte-serial header and pixel token parser with a two-entry result buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_s  : one beat per file byte (mode data), or a start / end-of-stream
//           marker. A start beat returns the parser to its reset state.
//   out_s : header beat after the maximum-value token, one pixel beat per
//           pixel token (last one marked), or an error beat on early end.
//   Each accepted beat updates the parser state; its result shows on out_s
//   the cycle after it if the result register is free or being read, else
//   it waits in the skid entry. One beat is taken every cycle while the
//   receiver keeps up, as the multiply-by-ten token update is combinational.
//   A result register plus one skid entry sit on the output: when out_s
//   stalls, beats that give no result keep flowing and one more result is
//   still held, then in_s.ready drops until the receiver drains the skid
//   entry.
//   Reset (rst_n low, synchronous) empties the output buffer and puts the
//   parser at the first magic byte.
// ----------------------------------------------------------------------------
module ascii_pgm_stream_parser #(
  parameter int DIM_BITS = apsp_pkg::DIM_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  apsp_in_if.sink    in_s,
  apsp_out_if.source out_s
);
  import apsp_pkg::*;

  localparam int PIX_BITS = 2 * DIM_BITS;
  localparam logic [TOKEN_BITS-1:0] DimMax = TOKEN_BITS'((64'd1 << DIM_BITS) - 64'd1);

  // Parser state
  phase_t                phase_r,    phase_nxt;
  logic [TOKEN_BITS-1:0] acc_r,      acc_nxt;
  logic                  open_r,     open_nxt;
  logic                  ended_r,    ended_nxt;
  logic [DIM_BITS-1:0]   width_r,    width_nxt;
  logic [DIM_BITS-1:0]   height_r,   height_nxt;
  logic [PIX_BITS-1:0]   pix_left_r, pix_left_nxt;

  // Output buffer
  res_beat_t out_r, skid_r;
  logic      out_valid_r, skid_valid_r;

  res_beat_t res;
  logic      res_valid;
  logic      accept, pop;

  logic                  is_digit, is_sep;
  logic [19:0]           acc_sum;
  logic [DIM_BITS-1:0]   dim_val;
  logic [PIX_BITS-1:0]   pix_prod;
  logic [PIX_BITS-1:0]   pix_dec;

  assign in_s.ready = !skid_valid_r;
  assign accept     = in_s.valid && in_s.ready;
  assign pop        = out_valid_r && out_s.ready;

  assign is_digit = (in_s.data_byte >= CH_ZERO) && (in_s.data_byte <= CH_NINE);
  assign is_sep   = (in_s.data_byte == CH_SPACE) || (in_s.data_byte == CH_NEWLINE);
  assign acc_sum  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                  + 20'(in_s.data_byte - CH_ZERO);
  assign dim_val  = (acc_r > DimMax) ? DimMax[DIM_BITS-1:0] : acc_r[DIM_BITS-1:0];
  assign pix_prod = PIX_BITS'(width_r) * PIX_BITS'(height_r);
  assign pix_dec  = pix_left_r - PIX_BITS'(1);

  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    open_nxt     = open_r;
    ended_nxt    = ended_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    pix_left_nxt = pix_left_r;
    res_valid    = 1'b0;
    res          = '{kind: KIND_HEADER, image_width: '0, image_height: '0,
                     pixel_value: '0, last_pixel: 1'b0, error_code: ERR_NONE};

    unique case (mode_t'(in_s.mode))
      MODE_START: begin
        phase_nxt    = PH_MAGIC0;
        acc_nxt      = '0;
        open_nxt     = 1'b0;
        ended_nxt    = 1'b0;
        width_nxt    = '0;
        height_nxt   = '0;
        pix_left_nxt = '0;
      end
      MODE_END: begin
        if (phase_r != PH_STOPPED) begin
          res_valid = 1'b1;
          if (phase_r == PH_PIXELS && open_r) begin
            pix_left_nxt    = pix_dec;
            res.kind        = KIND_PIXEL;
            res.pixel_value = acc_r[BYTE_BITS-1:0];
            if (pix_dec == '0) begin
              res.last_pixel = 1'b1;
            end else begin
              res.error_code = ERR_EARLY;
            end
          end else begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_EARLY;
          end
          acc_nxt   = '0;
          open_nxt  = 1'b0;
          ended_nxt = 1'b0;
          phase_nxt = PH_STOPPED;
        end
      end
      MODE_DATA: begin
        priority if (phase_r == PH_MAGIC0) begin
          phase_nxt = PH_MAGIC1;
        end else if (phase_r == PH_MAGIC1) begin
          phase_nxt = PH_WIDTH;
        end else if (phase_r == PH_STOPPED) begin
          phase_nxt = phase_r;
        end else if (is_sep) begin
          if (open_r) begin
            // close the token and act on it
            acc_nxt   = '0;
            open_nxt  = 1'b0;
            ended_nxt = 1'b0;
            unique case (phase_r)
              PH_WIDTH: begin
                width_nxt = dim_val;
                phase_nxt = PH_HEIGHT;
              end
              PH_HEIGHT: begin
                height_nxt = dim_val;
                phase_nxt  = PH_MAXV;
              end
              PH_MAXV: begin
                res_valid        = 1'b1;
                res.kind         = KIND_HEADER;
                res.image_width  = TOKEN_BITS'(width_r);
                res.image_height = TOKEN_BITS'(height_r);
                if (acc_r > GREY_MAX) begin
                  res.error_code = ERR_MAXVAL;
                  phase_nxt      = PH_STOPPED;
                end else begin
                  pix_left_nxt = pix_prod;
                  if (width_r == '0 || height_r == '0) begin
                    res.last_pixel = 1'b1;
                    phase_nxt      = PH_STOPPED;
                  end else begin
                    phase_nxt = PH_PIXELS;
                  end
                end
              end
              PH_PIXELS: begin
                res_valid       = 1'b1;
                res.kind        = KIND_PIXEL;
                res.pixel_value = acc_r[BYTE_BITS-1:0];
                pix_left_nxt    = pix_dec;
                if (pix_dec == '0) begin
                  res.last_pixel = 1'b1;
                  phase_nxt      = PH_STOPPED;
                end
              end
              default: phase_nxt = phase_r;
            endcase
          end
        end else begin
          open_nxt = 1'b1;
          if (!ended_r && is_digit) begin
            acc_nxt = (acc_sum[19:TOKEN_BITS] != '0) ? TOKEN_MAX : acc_sum[TOKEN_BITS-1:0];
          end else begin
            ended_nxt = 1'b1;
          end
        end
      end
      MODE_RSVD: begin
        phase_nxt = phase_r;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC0;
      acc_r      <= '0;
      open_r     <= 1'b0;
      ended_r    <= 1'b0;
      width_r    <= '0;
      height_r   <= '0;
      pix_left_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      open_r     <= open_nxt;
      ended_r    <= ended_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      pix_left_r <= pix_left_nxt;
    end
  end

  // Result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        // hold the new beat while the receiver stalls
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_s.valid        = out_valid_r;
  assign out_s.kind         = out_r.kind;
  assign out_s.image_width  = out_r.image_width;
  assign out_s.image_height = out_r.image_height;
  assign out_s.pixel_value  = out_r.pixel_value;
  assign out_s.last_pixel   = out_r.last_pixel;
  assign out_s.error_code   = out_r.error_code;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII greyscale image parser testbench
// Feeds byte streams of whole, cut-short and malformed images through the
// parser, predicts every header, pixel and error beat in a scoreboard and
// compares the results field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import apsp_pkg::*;

  localparam int          ITEM_TARGET = 1250;
  localparam int          QUIET_AFTER = 1050;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int unsigned DIM_MAX     = (1 << DIM_BITS_DEF) - 1;

  class pgm_scoreboard;
    phase_t      ph;
    logic [15:0] acc;
    bit          tok_open;
    bit          digits_done;
    logic [15:0] wd;
    logic [15:0] ht;
    logic [31:0] px_left;
    res_beat_t   pending[$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void clear_token();
      acc         = '0;
      tok_open    = 1'b0;
      digits_done = 1'b0;
    endfunction

    function void restart();
      ph      = PH_MAGIC0;
      clear_token();
      wd      = '0;
      ht      = '0;
      px_left = '0;
    endfunction

    function void queue_result(kind_t k, logic [15:0] w, logic [15:0] h, logic [7:0] p,
                               logic last, err_t e);
      res_beat_t r;
      r.kind         = k;
      r.image_width  = w;
      r.image_height = h;
      r.pixel_value  = p;
      r.last_pixel   = last;
      r.error_code   = e;
      pending.push_back(r);
    endfunction

    function void close_token();
      logic [15:0] v;
      v = acc;
      clear_token();
      case (ph)
        PH_WIDTH: begin
          wd = (32'(v) > DIM_MAX) ? 16'(DIM_MAX) : v;
          ph = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          ht = (32'(v) > DIM_MAX) ? 16'(DIM_MAX) : v;
          ph = PH_MAXV;
        end
        PH_MAXV: begin
          if (v > GREY_MAX) begin
            queue_result(KIND_HEADER, wd, ht, 8'd0, 1'b0, ERR_MAXVAL);
            ph = PH_STOPPED;
          end else begin
            px_left = 32'(wd) * 32'(ht);
            if (px_left == 0) begin
              queue_result(KIND_HEADER, wd, ht, 8'd0, 1'b1, ERR_NONE);
              ph = PH_STOPPED;
            end else begin
              queue_result(KIND_HEADER, wd, ht, 8'd0, 1'b0, ERR_NONE);
              ph = PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          px_left = px_left - 1;
          if (px_left == 0) begin
            queue_result(KIND_PIXEL, 16'd0, 16'd0, v[7:0], 1'b1, ERR_NONE);
            ph = PH_STOPPED;
          end else begin
            queue_result(KIND_PIXEL, 16'd0, 16'd0, v[7:0], 1'b0, ERR_NONE);
          end
        end
        default: ;
      endcase
    endfunction

    // Advance the parser copy by one accepted input beat.
    function void note_input(mode_t m, logic [7:0] b);
      logic [31:0] nxt;
      if (m == MODE_START) begin
        restart();
        return;
      end
      if (m == MODE_END) begin
        if (ph == PH_STOPPED) return;
        if (ph == PH_PIXELS && tok_open) begin
          px_left = px_left - 1;
          if (px_left == 0)
            queue_result(KIND_PIXEL, 16'd0, 16'd0, acc[7:0], 1'b1, ERR_NONE);
          else
            queue_result(KIND_PIXEL, 16'd0, 16'd0, acc[7:0], 1'b0, ERR_EARLY);
        end else begin
          queue_result(KIND_ERROR, 16'd0, 16'd0, 8'd0, 1'b0, ERR_EARLY);
        end
        clear_token();
        ph = PH_STOPPED;
        return;
      end
      if (m != MODE_DATA) return;
      case (ph)
        PH_MAGIC0: begin
          ph = PH_MAGIC1;
          return;
        end
        PH_MAGIC1: begin
          ph = PH_WIDTH;
          return;
        end
        PH_STOPPED: return;
        default: ;
      endcase
      if (b == CH_SPACE || b == CH_NEWLINE) begin
        if (tok_open) close_token();
        return;
      end
      tok_open = 1'b1;
      if (!digits_done && b >= CH_ZERO && b <= CH_NINE) begin
        nxt = 32'(acc) * 10 + 32'(b - CH_ZERO);
        acc = (nxt > 32'(TOKEN_MAX)) ? TOKEN_MAX : nxt[15:0];
      end else begin
        digits_done = 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(res_beat_t got);
      res_beat_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d", got.kind));
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind)
        report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.image_width != want.image_width)
        report_mismatch($sformatf("image_width got %0d want %0d",
                                  got.image_width, want.image_width));
      if (got.image_height != want.image_height)
        report_mismatch($sformatf("image_height got %0d want %0d",
                                  got.image_height, want.image_height));
      if (got.pixel_value != want.pixel_value)
        report_mismatch($sformatf("pixel_value got %0d want %0d",
                                  got.pixel_value, want.pixel_value));
      if (got.last_pixel != want.last_pixel)
        report_mismatch($sformatf("last_pixel got %0d want %0d",
                                  got.last_pixel, want.last_pixel));
      if (got.error_code != want.error_code)
        report_mismatch($sformatf("error_code got %0d want %0d",
                                  got.error_code, want.error_code));
    endtask
  endclass

  logic clk;
  logic rst_n;

  apsp_in_if  in_ch ();
  apsp_out_if out_ch ();

  ascii_pgm_stream_parser dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  pgm_scoreboard sb;
  res_beat_t     seen_beat;
  int            beats_sent = 0;
  int            cycles     = 0;
  int            stall_left = 0;
  bit            quiet      = 1'b0;
  bit            idle_on    = 1'b1;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check each beat, then decide the next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_beat.kind         = kind_t'(out_ch.kind);
      seen_beat.image_width  = out_ch.image_width;
      seen_beat.image_height = out_ch.image_height;
      seen_beat.pixel_value  = out_ch.pixel_value;
      seen_beat.last_pixel   = out_ch.last_pixel;
      seen_beat.error_code   = err_t'(out_ch.error_code);
      sb.check_result(seen_beat);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && !quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_beat(mode_t m, logic [7:0] b);
    if (idle_on && !quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(m, b);
    beats_sent++;
    if (beats_sent > QUIET_AFTER) quiet = 1'b1;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(MODE_DATA, s[i]);
  endtask

  task automatic send_seps();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    if ($urandom_range(0, 24) == 0) send_beat(MODE_RSVD, 8'($urandom));
    repeat (n) send_beat(MODE_DATA, $urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_SPACE || b == CH_NEWLINE || (b >= CH_ZERO && b <= CH_NINE));
    return b;
  endfunction

  // Write one token: optional leading zero, and for pixels optional junk
  // in front (value 0) or after the digits (value cut there).
  task automatic write_number(int unsigned v, bit allow_junk);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    if (allow_junk && $urandom_range(0, 19) == 0) send_beat(MODE_DATA, junk_byte());
    send_text(s);
    if (allow_junk && $urandom_range(0, 7) == 0) begin
      send_beat(MODE_DATA, junk_byte());
      if ($urandom_range(0, 1)) send_text("12");
    end
  endtask

  function automatic int unsigned pick_dim();
    if ($urandom_range(0, 19) != 0) return $urandom_range(0, 5);
    case ($urandom_range(0, 3))
      0:       return 65535;
      1:       return 70000;
      2:       return 300;
      default: return 4000;
    endcase
  endfunction

  function automatic int unsigned pick_maxv();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(256, 70000);
      1:       return 0;
      2:       return 255;
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  function automatic int unsigned pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(256, 65535);
      3:       return $urandom_range(65536, 999999);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic longint unsigned sat16(int unsigned v);
    return (v > 65535) ? 65535 : v;
  endfunction

  task automatic gen_image();
    int unsigned     w, h, mv, sel, cut;
    longint unsigned full, nsend;
    bit              open_end;
    idle_on = ($urandom_range(0, 3) != 0);
    send_beat(MODE_START, 8'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      send_beat(MODE_DATA, 8'($urandom));
      send_beat(MODE_DATA, 8'($urandom));
    end else begin
      send_text("P2");
    end
    if ($urandom_range(0, 1)) send_seps();
    w        = pick_dim();
    h        = pick_dim();
    mv       = pick_maxv();
    sel      = $urandom_range(0, 9);
    open_end = $urandom_range(0, 1);

    // Stream cut inside the header.
    if (sel == 0) begin
      cut = $urandom_range(0, 2);
      if (cut > 0) begin
        write_number(w, 1'b0);
        send_seps();
      end
      if (cut > 1) begin
        write_number(h, 1'b0);
        send_seps();
      end
      if (open_end) write_number(mv, 1'b0);
      send_beat(MODE_END, 8'($urandom));
      return;
    end

    write_number(w, 1'b0);
    send_seps();
    write_number(h, 1'b0);
    send_seps();
    write_number(mv, 1'b0);
    send_seps();
    full = sat16(w) * sat16(h);

    if (mv > 255 || full == 0) begin
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 4)) send_beat(MODE_DATA, 8'($urandom));
      if ($urandom_range(0, 1)) send_beat(MODE_END, 8'($urandom));
      return;
    end

    if (sel <= 2 || full > 60) nsend = $urandom_range(0, 32'((full > 10) ? 10 : full - 1));
    else nsend = full;

    for (longint unsigned i = 0; i < nsend; i++) begin
      write_number(pick_pixel(), 1'b1);
      if (i + 1 < nsend || !open_end) send_seps();
    end

    if (nsend < full) begin
      // Leave some images unfinished so the next start aborts them.
      if ($urandom_range(0, 4) != 0) send_beat(MODE_END, 8'($urandom));
    end else begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5)) send_beat(MODE_DATA, 8'($urandom));
      if ($urandom_range(0, 1)) send_beat(MODE_END, 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_DATA;
    in_ch.data_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Open pixel token closed by end, junk suffix, saturation, reserved
    // mode, end while stopped, maximum above 255, empty image at max width.
    send_beat(MODE_START, 8'h00);
    send_text("P2 2 1 9\n7x 99999");
    send_beat(MODE_END, 8'hFF);
    send_beat(MODE_RSVD, 8'h80);
    send_beat(MODE_END, 8'h00);
    send_beat(MODE_START, 8'h7F);
    send_text("P20 4 300 ");
    send_beat(MODE_START, 8'hAA);
    send_text("P2 65535 0 255\n5");
    send_beat(MODE_DATA, 8'hFF);

    while (beats_sent < ITEM_TARGET) gen_image();
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
